>>> hdl/calclk_pkg.sv
// ----------------------------------------------------------------------------
// calclk_pkg
// shared types, key codes, widths and reset values of the calendar clock
// ----------------------------------------------------------------------------
package calclk_pkg;

  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned FIELD_W     = 7;
  localparam int unsigned CURSOR_W    = 4;
  localparam int unsigned KEY_W       = 5;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [KEY_W-1:0] KEY_UP    = 5'd2;
  localparam logic [KEY_W-1:0] KEY_A     = 5'd4;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 5'd5;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 5'd7;
  localparam logic [KEY_W-1:0] KEY_B     = 5'd8;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 5'd10;
  localparam logic [KEY_W-1:0] KEY_C     = 5'd12;
  localparam logic [KEY_W-1:0] KEY_D     = 5'd16;

  localparam logic CMD_TICK = 1'b0;

  localparam logic [YEAR_W-1:0]   YEAR_RESET  = 14'd2022;
  localparam logic [YEAR_W-1:0]   YEAR_MAX    = 14'd9999;
  localparam logic [FIELD_W-1:0]  MONTH_RESET = 7'd1;
  localparam logic [FIELD_W-1:0]  DAY_RESET   = 7'd1;
  localparam logic [CURSOR_W-1:0] CURSOR_LAST = 4'd13;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_ENTER,
    OP_LEAVE,
    OP_VERT,
    OP_LEFT,
    OP_RIGHT,
    OP_INC,
    OP_DEC
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
  } op_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
  } cal_t;

endpackage

>>> hdl/calclk_front.sv
// ----------------------------------------------------------------------------
// calclk_front
// decodes an incoming tick or key press into an operation for the queue
// ----------------------------------------------------------------------------
module calclk_front (
  input  logic                         valid_i,
  input  logic                         cmd_i,
  input  logic [calclk_pkg::KEY_W-1:0] key_code_i,
  input  logic                         full_i,
  output logic                         ready_o,
  output calclk_pkg::op_req_t          push_o
);

  calclk_pkg::op_e op;

  always_comb begin
    op = calclk_pkg::OP_NONE;
    if (cmd_i == calclk_pkg::CMD_TICK) begin
      op = calclk_pkg::OP_TICK;
    end else begin
      case (key_code_i)
        calclk_pkg::KEY_A:     op = calclk_pkg::OP_ENTER;
        calclk_pkg::KEY_B:     op = calclk_pkg::OP_LEAVE;
        calclk_pkg::KEY_UP:    op = calclk_pkg::OP_VERT;
        calclk_pkg::KEY_DOWN:  op = calclk_pkg::OP_VERT;
        calclk_pkg::KEY_LEFT:  op = calclk_pkg::OP_LEFT;
        calclk_pkg::KEY_RIGHT: op = calclk_pkg::OP_RIGHT;
        calclk_pkg::KEY_C:     op = calclk_pkg::OP_INC;
        calclk_pkg::KEY_D:     op = calclk_pkg::OP_DEC;
        default:               op = calclk_pkg::OP_NONE;
      endcase
    end
  end

  assign ready_o      = !full_i;
  assign push_o.valid = valid_i && !full_i;
  assign push_o.op    = op;

endmodule

>>> hdl/calclk_queue.sv
// ----------------------------------------------------------------------------
// calclk_queue
// short first-in first-out queue of decoded operations
// ----------------------------------------------------------------------------
module calclk_queue #(
  parameter int unsigned Depth = calclk_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  calclk_pkg::op_req_t push_i,
  input  logic                pop_i,
  output logic                full_o,
  output calclk_pkg::op_req_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  calclk_pkg::op_e       mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != '0);
  assign head_o.op    = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.op;
    end
  end

endmodule

>>> hdl/calclk_back.sv
// ----------------------------------------------------------------------------
// calclk_back
// executes queued operations on the date, time, cursor and mode registers
// ----------------------------------------------------------------------------
module calclk_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  calclk_pkg::op_req_t             head_i,
  output logic                            pop_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output calclk_pkg::cal_t                cal_o,
  output logic [calclk_pkg::CURSOR_W-1:0] cursor_o,
  output logic                            set_mode_o
);

  localparam int unsigned YW = calclk_pkg::YEAR_W;
  localparam int unsigned FW = calclk_pkg::FIELD_W;
  localparam int unsigned CW = calclk_pkg::CURSOR_W;

  calclk_pkg::cal_t cal_q, cal_d, cal_norm, cal_tick, cal_edit;
  logic [CW-1:0]    cursor_q, cursor_d;
  logic             mode_q, mode_d;
  logic             out_valid_q, out_valid_d;

  logic [YW-1:0]    fld, step, fld_new;
  logic [YW:0]      limit, sum;
  logic             edit_en, edit_ok, up;

  // reciprocal of 100 avoids a divider
  function automatic logic is_leap(logic [YW-1:0] y);
    logic [26:0] prod;
    logic        div100;
    prod   = 27'(y) * 27'd5243;
    div100 = (prod[18:12] == '0);
    return div100 ? (prod[20:19] == 2'd0) : (y[1:0] == 2'd0);
  endfunction

  function automatic logic [4:0] month_len(logic [FW-1:0] m, logic [YW-1:0] y);
    logic [4:0] len;
    case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = is_leap(y) ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic calclk_pkg::cal_t normalize(calclk_pkg::cal_t c);
    calclk_pkg::cal_t r;
    logic [5:0]       len1;
    r = c;
    if (r.second == 7'd60) begin
      r.minute = r.minute + 7'd1;
      r.second = '0;
    end else if (r.second > 7'd60) begin
      r.second = '0;
    end
    if (r.minute == 7'd60) begin
      r.hour   = r.hour + 7'd1;
      r.minute = '0;
    end else if (r.minute > 7'd60) begin
      r.minute = '0;
    end
    if (r.hour == 7'd24) begin
      r.hour = '0;
      r.day  = r.day + 7'd1;
    end else if (r.hour > 7'd24) begin
      r.hour = '0;
    end
    len1 = {1'b0, month_len(r.month, r.year)} + 6'd1;
    if (r.day == FW'(len1)) begin
      r.month = r.month + 7'd1;
      r.day   = calclk_pkg::DAY_RESET;
    end else if (r.day == '0 || r.day > FW'(len1)) begin
      r.day = calclk_pkg::DAY_RESET;
    end
    if (r.month > 7'd13) begin
      r.month = calclk_pkg::MONTH_RESET;
    end else if (r.month == 7'd13) begin
      r.year  = r.year + 14'd1;
      r.month = calclk_pkg::MONTH_RESET;
    end else if (r.month == '0) begin
      r.month = calclk_pkg::MONTH_RESET;
    end
    if (r.year == '0 || r.year > calclk_pkg::YEAR_MAX) begin
      r.year = calclk_pkg::YEAR_RESET;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] move_vert(logic [CW-1:0] c);
    logic [CW-1:0] n;
    case (c) inside
      [4'd0:4'd5]:  n = c + 4'd8;
      [4'd6:4'd7]:  n = calclk_pkg::CURSOR_LAST;
      [4'd8:4'd13]: n = c - 4'd8;
      default:      n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [CW-1:0] move_left(logic [CW-1:0] c);
    logic [CW-1:0] n;
    case (c) inside
      4'd0:         n = 4'd7;
      4'd8:         n = calclk_pkg::CURSOR_LAST;
      [4'd1:4'd13]: n = c - 4'd1;
      default:      n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [CW-1:0] move_right(logic [CW-1:0] c);
    logic [CW-1:0] n;
    case (c) inside
      4'd7:         n = '0;
      4'd13:        n = 4'd8;
      [4'd0:4'd12]: n = c + 4'd1;
      default:      n = '0;
    endcase
    return n;
  endfunction

  assign pop_o = head_i.valid && (!out_valid_q || out_ready_i);

  // field under the cursor and its step
  always_comb begin
    fld     = '0;
    step    = 14'd1;
    limit   = 15'd100;
    edit_en = 1'b1;
    case (cursor_q) inside
      [4'd0:4'd1]: begin
        fld = YW'(cal_q.month);
      end
      [4'd2:4'd3]: begin
        fld = YW'(cal_q.day);
      end
      [4'd4:4'd7]: begin
        fld   = cal_q.year;
        limit = 15'd10000;
      end
      [4'd8:4'd9]: begin
        fld = YW'(cal_q.hour);
      end
      [4'd10:4'd11]: begin
        fld = YW'(cal_q.minute);
      end
      [4'd12:4'd13]: begin
        fld = YW'(cal_q.second);
      end
      default: begin
        edit_en = 1'b0;
      end
    endcase
    case (cursor_q)
      4'd4:                                    step = 14'd1000;
      4'd5:                                    step = 14'd100;
      4'd0, 4'd2, 4'd6, 4'd8, 4'd10, 4'd12:    step = 14'd10;
      default:                                 step = 14'd1;
    endcase
  end

  assign up      = (head_i.op == calclk_pkg::OP_INC);
  assign sum     = {1'b0, fld} + {1'b0, step};
  assign edit_ok = edit_en && (up ? (sum < limit) : (fld >= step));
  assign fld_new = up ? sum[YW-1:0] : fld - step;

  always_comb begin
    cal_edit = cal_q;
    if (edit_ok) begin
      case (cursor_q) inside
        [4'd0:4'd1]:   cal_edit.month  = fld_new[FW-1:0];
        [4'd2:4'd3]:   cal_edit.day    = fld_new[FW-1:0];
        [4'd4:4'd7]:   cal_edit.year   = fld_new;
        [4'd8:4'd9]:   cal_edit.hour   = fld_new[FW-1:0];
        [4'd10:4'd11]: cal_edit.minute = fld_new[FW-1:0];
        default:       cal_edit.second = fld_new[FW-1:0];
      endcase
    end
  end

  always_comb begin
    cal_tick        = cal_q;
    cal_tick.second = cal_q.second + 7'd1;
    cal_norm        = normalize((head_i.op == calclk_pkg::OP_TICK) ? cal_tick : cal_q);
  end

  always_comb begin
    cal_d    = cal_q;
    cursor_d = cursor_q;
    mode_d   = mode_q;
    if (!mode_q) begin
      case (head_i.op)
        calclk_pkg::OP_TICK: begin
          cal_d = cal_norm;
        end
        calclk_pkg::OP_ENTER: begin
          mode_d   = 1'b1;
          cursor_d = '0;
        end
        default: begin
        end
      endcase
    end else begin
      case (head_i.op)
        calclk_pkg::OP_LEAVE: begin
          cal_d    = cal_norm;
          mode_d   = 1'b0;
          cursor_d = '0;
        end
        calclk_pkg::OP_VERT:  cursor_d = move_vert(cursor_q);
        calclk_pkg::OP_LEFT:  cursor_d = move_left(cursor_q);
        calclk_pkg::OP_RIGHT: cursor_d = move_right(cursor_q);
        calclk_pkg::OP_INC:   cal_d    = cal_edit;
        calclk_pkg::OP_DEC:   cal_d    = cal_edit;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.year   <= calclk_pkg::YEAR_RESET;
      cal_q.month  <= calclk_pkg::MONTH_RESET;
      cal_q.day    <= calclk_pkg::DAY_RESET;
      cal_q.hour   <= '0;
      cal_q.minute <= '0;
      cal_q.second <= '0;
      cursor_q     <= '0;
      mode_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        cal_q    <= cal_d;
        cursor_q <= cursor_d;
        mode_q   <= mode_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign cal_o       = cal_q;
  assign cursor_o    = cursor_q;
  assign set_mode_o  = mode_q;

endmodule

>>> hdl/calendar_clock_with_set_mode_core.sv
// ----------------------------------------------------------------------------
// calendar_clock_with_set_mode_core
// calendar clock with run and set modes, driven by ticks and key presses
// ----------------------------------------------------------------------------
// channel   | direction | tdata                      | tuser
// s_axis    | in        | key_code [4:0]             | cmd (0 tick, 1 key)
// m_axis    | out       | date, time, cursor, mode   | -
//
// one item per cycle sustained while m_axis_tready is high; each accepted item
// is registered in the decode queue, then in the state update stage
// the result is held in the state registers, so a stalled output stops the
// update stage and the queue fills; tready falls when the queue is full
// reset gives 2022-01-01 00:00:00, run mode, cursor 0, queue empty
// ----------------------------------------------------------------------------
module calendar_clock_with_set_mode_core #(
  parameter int unsigned QueueDepth = calclk_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // key_code [4:0], zero [7:5]
  input  logic [calclk_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd [0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // year [13:0], month [20:14], day [27:21], hour [34:28], minute [41:35],
  // second [48:42], cursor [52:49], set_mode [53], zero [55:54]
  output logic [calclk_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  calclk_pkg::op_req_t                 push, head;
  logic                                full, pop;
  calclk_pkg::cal_t                    cal;
  logic [calclk_pkg::CURSOR_W-1:0]     cursor;
  logic                                set_mode;

  calclk_front u_front (
    .valid_i    (s_axis_tvalid),
    .cmd_i      (s_axis_tuser),
    .key_code_i (s_axis_tdata[calclk_pkg::KEY_W-1:0]),
    .full_i     (full),
    .ready_o    (s_axis_tready),
    .push_o     (push)
  );

  calclk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  calclk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cal_o       (cal),
    .cursor_o    (cursor),
    .set_mode_o  (set_mode)
  );

  assign m_axis_tdata = {2'b00, set_mode, cursor, cal.second, cal.minute, cal.hour,
                         cal.day, cal.month, cal.year};

`ifndef SYNTHESIS
  a_run_cursor_home : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !set_mode) |-> (cursor == '0))
    else $error("cursor away from home in run mode");

  a_cursor_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cursor <= calclk_pkg::CURSOR_LAST))
    else $error("cursor beyond last digit");

  a_run_normalised : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !set_mode) |->
      (cal.second < 7'd60 && cal.minute < 7'd60 && cal.hour < 7'd24 &&
       cal.month >= 7'd1 && cal.month <= 7'd12 && cal.day >= 7'd1 && cal.day <= 7'd31 &&
       cal.year >= 14'd1 && cal.year <= calclk_pkg::YEAR_MAX))
    else $error("date or time not normalised in run mode");
`endif

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the calendar clock: a short table of ticks and key
// presses, then random edit sessions that dial fields to rollover and
// out-of-range values, checked against the table or a behavioural model of the clock
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int YW = calclk_pkg::YEAR_W;
  localparam int FW = calclk_pkg::FIELD_W;
  localparam int CW = calclk_pkg::CURSOR_W;
  localparam int KW = calclk_pkg::KEY_W;

  localparam logic CMD_KEY     = ~calclk_pkg::CMD_TICK;
  localparam int   ITEMS       = 700;
  localparam int   HOLD_AT     = 350;
  localparam int   HOLD_CYCLES = 120;
  localparam int   IDLE_LIMIT  = 2000;

  localparam int CUR_MONTH  = 0;
  localparam int CUR_DAY    = 2;
  localparam int CUR_YEAR   = 4;
  localparam int CUR_HOUR   = 8;
  localparam int CUR_MINUTE = 10;
  localparam int CUR_SECOND = 12;

  typedef enum int {FLD_MONTH, FLD_DAY, FLD_YEAR, FLD_HOUR, FLD_MINUTE, FLD_SECOND} field_e;

  typedef struct packed {
    logic          set_mode;
    logic [CW-1:0] cursor;
    logic [FW-1:0] second;
    logic [FW-1:0] minute;
    logic [FW-1:0] hour;
    logic [FW-1:0] day;
    logic [FW-1:0] month;
    logic [YW-1:0] year;
  } readout_t;

  typedef struct {
    logic          cmd;
    logic [KW-1:0] key;
    bit            typed;
    readout_t      want;
  } row_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [calclk_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                               s_axis_tuser;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [calclk_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // clock model
  logic [YW-1:0] clk_year;
  logic [FW-1:0] clk_month, clk_day, clk_hour, clk_minute, clk_second;
  logic [CW-1:0] edit_pos;
  logic          setting;

  readout_t due_readouts[$];
  row_t     rows[$];
  int       items_in, ticks_in, keys_in, readouts_seen, mismatches, date_rolls;
  bit       calm, hold_req;

  calendar_clock_with_set_mode_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic readout_t reading(input int y, input int mo, input int d, input int h,
                                       input int mi, input int s, input int c, input int m);
    readout_t r;
    r.year = YW'(y); r.month = FW'(mo); r.day = FW'(d); r.hour = FW'(h);
    r.minute = FW'(mi); r.second = FW'(s);
    r.cursor = CW'(c); r.set_mode = (m != 0);
    return r;
  endfunction

  function automatic int month_days(input int y, input int m);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return ((y % 400 == 0) || (y % 4 == 0 && y % 100 != 0)) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic int field_at(input int pos);
    if (pos < CUR_DAY) return int'(clk_month);
    if (pos < CUR_YEAR) return int'(clk_day);
    if (pos < CUR_HOUR) return int'(clk_year);
    if (pos < CUR_MINUTE) return int'(clk_hour);
    if (pos < CUR_SECOND) return int'(clk_minute);
    return int'(clk_second);
  endfunction

  task automatic settle_calendar();
    int len;
    if (clk_second == 60) begin
      clk_minute++;
      clk_second = '0;
    end else if (clk_second > 60) begin
      clk_second = '0;
    end
    if (clk_minute == 60) begin
      clk_hour++;
      clk_minute = '0;
    end else if (clk_minute > 60) begin
      clk_minute = '0;
    end
    if (clk_hour == 24) begin
      clk_hour = '0;
      clk_day++;
    end else if (clk_hour > 24) begin
      clk_hour = '0;
    end
    len = month_days(int'(clk_year), int'(clk_month));
    if (clk_day == len + 1) begin
      clk_month++;
      clk_day = calclk_pkg::DAY_RESET;
    end else if (clk_day == 0 || clk_day > len + 1) begin
      clk_day = calclk_pkg::DAY_RESET;
    end
    if (clk_month > 13) begin
      clk_month = calclk_pkg::MONTH_RESET;
    end else if (clk_month == 13) begin
      clk_year++;
      clk_month = calclk_pkg::MONTH_RESET;
    end else if (clk_month == 0) begin
      clk_month = calclk_pkg::MONTH_RESET;
    end
    if (clk_year == 0 || clk_year > calclk_pkg::YEAR_MAX) clk_year = calclk_pkg::YEAR_RESET;
  endtask

  task automatic edit_digit(input bit up);
    int step, lim, val;
    if (edit_pos > calclk_pkg::CURSOR_LAST) return;
    if (edit_pos == CUR_YEAR) step = 1000;
    else if (edit_pos == CUR_YEAR + 1) step = 100;
    else step = (edit_pos % 2 == 0) ? 10 : 1;
    lim = (edit_pos >= CUR_YEAR && edit_pos < CUR_HOUR) ? 10000 : 100;
    val = field_at(int'(edit_pos));
    if (up) begin
      if (val + step < lim) val += step;
    end else if (val >= step) begin
      val -= step;
    end
    if (edit_pos < CUR_DAY) clk_month = FW'(val);
    else if (edit_pos < CUR_YEAR) clk_day = FW'(val);
    else if (edit_pos < CUR_HOUR) clk_year = YW'(val);
    else if (edit_pos < CUR_MINUTE) clk_hour = FW'(val);
    else if (edit_pos < CUR_SECOND) clk_minute = FW'(val);
    else clk_second = FW'(val);
  endtask

  task automatic advance_clock(input logic cmd, input logic [KW-1:0] key,
                               output readout_t r);
    logic [FW-1:0] day_was;
    if (cmd == calclk_pkg::CMD_TICK) begin
      if (!setting) begin
        day_was = clk_day;
        clk_second++;
        settle_calendar();
        if (clk_day != day_was) date_rolls++;
      end
    end else if (!setting) begin
      if (key == calclk_pkg::KEY_A) begin
        setting = 1'b1;
        edit_pos = '0;
      end
    end else begin
      case (key)
        calclk_pkg::KEY_B: begin
          settle_calendar();
          setting = 1'b0;
          edit_pos = '0;
        end
        calclk_pkg::KEY_UP, calclk_pkg::KEY_DOWN: begin
          if (edit_pos <= 5) edit_pos = edit_pos + CW'(8);
          else if (edit_pos <= 7) edit_pos = calclk_pkg::CURSOR_LAST;
          else edit_pos = edit_pos - CW'(8);
        end
        calclk_pkg::KEY_LEFT: begin
          if (edit_pos == 0) edit_pos = CW'(7);
          else if (edit_pos == 8) edit_pos = calclk_pkg::CURSOR_LAST;
          else edit_pos = edit_pos - CW'(1);
        end
        calclk_pkg::KEY_RIGHT: begin
          if (edit_pos == 7) edit_pos = '0;
          else if (edit_pos == calclk_pkg::CURSOR_LAST) edit_pos = CW'(8);
          else edit_pos = edit_pos + CW'(1);
        end
        calclk_pkg::KEY_C: edit_digit(1'b1);
        calclk_pkg::KEY_D: edit_digit(1'b0);
        default: ;
      endcase
    end
    r = reading(int'(clk_year), int'(clk_month), int'(clk_day), int'(clk_hour),
                int'(clk_minute), int'(clk_second), int'(edit_pos), int'(setting));
  endtask

  function automatic int sender_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic push_item(input logic cmd, input logic [KW-1:0] key, input bit typed,
                           input readout_t want);
    int gap;
    readout_t r;
    gap = sender_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(calclk_pkg::IN_TDATA_W-KW){1'b0}}, key};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_clock(cmd, key, r);
    due_readouts.push_back(typed ? want : r);
    items_in++;
    if (cmd == calclk_pkg::CMD_TICK) ticks_in++;
    else keys_in++;
    if (items_in == HOLD_AT) hold_req = 1'b1;
  endtask

  task automatic press(input logic [KW-1:0] key);
    push_item(CMD_KEY, key, 1'b0, '0);
  endtask

  task automatic tick();
    push_item(calclk_pkg::CMD_TICK, KW'($urandom_range(0, 31)), 1'b0, '0);
  endtask

  task automatic go_to(input int target);
    while (edit_pos != target) begin
      if ((edit_pos < CUR_HOUR) != (target < CUR_HOUR))
        press(($urandom_range(0, 1) == 1) ? calclk_pkg::KEY_UP : calclk_pkg::KEY_DOWN);
      else
        press(($urandom_range(0, 1) == 1) ? calclk_pkg::KEY_LEFT : calclk_pkg::KEY_RIGHT);
    end
  endtask

  // walk the digits of a field from the most significant one
  task automatic dial_field(input field_e f, input int target);
    int first, ndig, now_v, w, delta;
    case (f)
      FLD_MONTH:  first = CUR_MONTH;
      FLD_DAY:    first = CUR_DAY;
      FLD_YEAR:   first = CUR_YEAR;
      FLD_HOUR:   first = CUR_HOUR;
      FLD_MINUTE: first = CUR_MINUTE;
      default:    first = CUR_SECOND;
    endcase
    ndig  = (f == FLD_YEAR) ? 4 : 2;
    w     = (f == FLD_YEAR) ? 1000 : 10;
    now_v = field_at(first);
    for (int d = 0; d < ndig; d++) begin
      delta = (target / w) % 10 - (now_v / w) % 10;
      go_to(first + d);
      repeat ((delta < 0) ? -delta : delta)
        press((delta < 0) ? calclk_pkg::KEY_D : calclk_pkg::KEY_C);
      w = w / 10;
    end
  endtask

  function automatic int pick_target(input field_e f);
    int r;
    r = $urandom_range(0, 9);
    case (f)
      FLD_MONTH: begin
        case (r)
          0: return 0;
          1: return 2;
          2: return 12;
          3: return 13;
          4: return 14;
          5: return 99;
          default: return $urandom_range(1, 12);
        endcase
      end
      FLD_DAY: begin
        case (r)
          0: return 0;
          1: return 28;
          2: return 29;
          3: return 30;
          4: return 31;
          5: return 32;
          6: return 99;
          default: return $urandom_range(1, 99);
        endcase
      end
      FLD_YEAR: begin
        case (r)
          0: return 0;
          1: return 1900;
          2: return 2000;
          3: return 2024;
          4: return 9999;
          5: return 1;
          default: return $urandom_range(0, 9999);
        endcase
      end
      FLD_HOUR: begin
        case (r)
          0: return 23;
          1: return 24;
          2: return 25;
          3: return 99;
          default: return $urandom_range(0, 99);
        endcase
      end
      default: begin
        case (r)
          0: return 58;
          1: return 59;
          2: return 60;
          3: return 61;
          4: return 99;
          5: return 0;
          default: return $urandom_range(0, 99);
        endcase
      end
    endcase
  endfunction

  task automatic run_session();
    int r;
    field_e f;
    calm = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 6))
        push_item($urandom_range(0, 1) == 1, KW'($urandom_range(0, 31)), 1'b0, '0);
    end else if (r < 45) begin
      // set up a midnight rollover at a month end, sometimes at a year end
      press(calclk_pkg::KEY_A);
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 5))
          0: dial_field(FLD_YEAR, 1900);
          1: dial_field(FLD_YEAR, 2000);
          2: dial_field(FLD_YEAR, 2023);
          3: dial_field(FLD_YEAR, 2024);
          4: dial_field(FLD_YEAR, 2100);
          default: dial_field(FLD_YEAR, 9999);
        endcase
      end
      case ($urandom_range(0, 2))
        0: dial_field(FLD_MONTH, 12);
        1: dial_field(FLD_MONTH, 2);
        default: dial_field(FLD_MONTH, $urandom_range(1, 12));
      endcase
      dial_field(FLD_DAY, month_days(int'(clk_year), int'(clk_month)));
      dial_field(FLD_HOUR, 23);
      dial_field(FLD_MINUTE, 59);
      dial_field(FLD_SECOND, $urandom_range(55, 59));
      press(calclk_pkg::KEY_B);
      repeat ($urandom_range(3, 8)) tick();
    end else begin
      press(calclk_pkg::KEY_A);
      repeat ($urandom_range(1, 4)) begin
        f = field_e'($urandom_range(0, 5));
        dial_field(f, pick_target(f));
      end
      if ($urandom_range(0, 2) == 0) begin
        go_to(int'($urandom_range(0, calclk_pkg::CURSOR_LAST)));
        repeat ($urandom_range(1, 4))
          press(($urandom_range(0, 1) == 1) ? calclk_pkg::KEY_C : calclk_pkg::KEY_D);
      end
      if ($urandom_range(0, 5) == 0) begin
        tick();
        press(calclk_pkg::KEY_A);
        press(KW'($urandom_range(17, 31)));
      end
      if ($urandom_range(0, 9) != 0) press(calclk_pkg::KEY_B);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(58, 64)) tick();
      else repeat ($urandom_range(0, 8)) tick();
    end
  endtask

  task automatic add_row(input logic cmd, input logic [KW-1:0] key, input bit typed,
                         input readout_t want);
    row_t row;
    row.cmd = cmd; row.key = key; row.typed = typed; row.want = want;
    rows.push_back(row);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endtask

  // output side: ready with random stalls, plus one long hold-off
  initial begin
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !calm) begin
        case ($urandom_range(0, 99)) inside
          [0:19]:  stall = $urandom_range(1, 3);
          [20:22]: stall = $urandom_range(15, 40);
          default: stall = 0;
        endcase
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    readout_t seen, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata[$bits(readout_t)-1:0];
      readouts_seen++;
      if (due_readouts.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = due_readouts.pop_front();
        check_field("year", 32'(want.year), 32'(seen.year));
        check_field("month", 32'(want.month), 32'(seen.month));
        check_field("day", 32'(want.day), 32'(seen.day));
        check_field("hour", 32'(want.hour), 32'(seen.hour));
        check_field("minute", 32'(want.minute), 32'(seen.minute));
        check_field("second", 32'(want.second), 32'(seen.second));
        check_field("cursor", 32'(want.cursor), 32'(seen.cursor));
        check_field("set_mode", 32'(want.set_mode), 32'(seen.set_mode));
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout: %0d cycles without a handshake", IDLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= calclk_pkg::CMD_TICK;
    calm     = 1'b0;
    hold_req = 1'b0;
    clk_year = calclk_pkg::YEAR_RESET;
    clk_month = calclk_pkg::MONTH_RESET;
    clk_day = calclk_pkg::DAY_RESET;
    clk_hour = '0; clk_minute = '0; clk_second = '0; edit_pos = '0; setting = 1'b0;

    add_row(calclk_pkg::CMD_TICK, '0, 1, reading(2022, 1, 1, 0, 0, 1, 0, 0));
    add_row(CMD_KEY, calclk_pkg::KEY_C, 1, reading(2022, 1, 1, 0, 0, 1, 0, 0));
    add_row(CMD_KEY, '0, 1, reading(2022, 1, 1, 0, 0, 1, 0, 0));
    add_row(CMD_KEY, calclk_pkg::KEY_A, 1, reading(2022, 1, 1, 0, 0, 1, 0, 1));
    add_row(calclk_pkg::CMD_TICK, '1, 1, reading(2022, 1, 1, 0, 0, 1, 0, 1));
    add_row(CMD_KEY, calclk_pkg::KEY_A, 1, reading(2022, 1, 1, 0, 0, 1, 0, 1));
    add_row(CMD_KEY, calclk_pkg::KEY_LEFT, 1, reading(2022, 1, 1, 0, 0, 1, 7, 1));
    add_row(CMD_KEY, calclk_pkg::KEY_RIGHT, 1, reading(2022, 1, 1, 0, 0, 1, 0, 1));
    add_row(CMD_KEY, calclk_pkg::KEY_D, 1, reading(2022, 1, 1, 0, 0, 1, 0, 1));
    add_row(CMD_KEY, calclk_pkg::KEY_RIGHT, 0, '0);
    add_row(CMD_KEY, calclk_pkg::KEY_D, 1, reading(2022, 0, 1, 0, 0, 1, 1, 1));
    add_row(CMD_KEY, calclk_pkg::KEY_UP, 1, reading(2022, 0, 1, 0, 0, 1, 9, 1));
    add_row(CMD_KEY, '1, 1, reading(2022, 0, 1, 0, 0, 1, 9, 1));
    add_row(CMD_KEY, calclk_pkg::KEY_LEFT, 0, '0);
    add_row(CMD_KEY, calclk_pkg::KEY_LEFT, 1, reading(2022, 0, 1, 0, 0, 1, 13, 1));
    add_row(CMD_KEY, calclk_pkg::KEY_C, 0, '0);
    add_row(CMD_KEY, calclk_pkg::KEY_DOWN, 0, '0);
    add_row(CMD_KEY, calclk_pkg::KEY_C, 0, '0);
    add_row(CMD_KEY, calclk_pkg::KEY_LEFT, 0, '0);
    add_row(CMD_KEY, calclk_pkg::KEY_D, 0, '0);
    add_row(CMD_KEY, calclk_pkg::KEY_D, 0, '0);
    add_row(CMD_KEY, calclk_pkg::KEY_D, 1, reading(122, 0, 1, 0, 0, 2, 4, 1));
    add_row(CMD_KEY, calclk_pkg::KEY_B, 1, reading(122, 1, 1, 0, 0, 2, 0, 0));
    add_row(calclk_pkg::CMD_TICK, '0, 0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) push_item(rows[i].cmd, rows[i].key, rows[i].typed, rows[i].want);
    while (items_in < ITEMS) run_session();
    s_axis_tvalid <= 1'b0;

    while (due_readouts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("%0d items sent (%0d ticks, %0d key presses), %0d results compared",
             items_in, ticks_in, keys_in, readouts_seen);
    $display("%0d date rollovers in run mode, one long output hold-off of %0d cycles",
             date_rolls, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/calclk_pkg.sv
hdl/calclk_front.sv
hdl/calclk_queue.sv
hdl/calclk_back.sv
hdl/calendar_clock_with_set_mode_core.sv
test/tb.sv
